FILE: rtl/core/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg - shared definitions for the bounded ordered list engine
// Command and status codes, field widths and stream word layouts.
// ----------------------------------------------------------------------------
package bole_pkg;

	// field widths
	localparam int CMD_W     = 3;
	localparam int OPERAND_W = 32;
	localparam int STATUS_W  = 2;
	localparam int ELEM_W    = 32;
	localparam int RCNT_W    = 7;

	// stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [OPERAND_W-1:0] operand_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [ELEM_W-1:0]    elem_t;
	typedef logic [RCNT_W-1:0]    rcnt_t;

	// commands
	localparam cmd_t CMD_INS_FRONT = 3'd0;
	localparam cmd_t CMD_INS_BACK  = 3'd1;
	localparam cmd_t CMD_DUMP      = 3'd2;
	localparam cmd_t CMD_REMOVE    = 3'd3;
	localparam cmd_t CMD_CLEAR     = 3'd4;

	// result status
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_EMPTY    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

endpackage

FILE: rtl/core/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine - ordered list of signed words in a ring store
// Insert at front or back, dump in order, remove all matches, clear.
// ----------------------------------------------------------------------------
//
//  channel   direction  word contents (low bit first)
//  s_axis    in         tdata: cmd[2:0], operand_value[34:3], zero pad to 40
//  m_axis    out        tdata: status[1:0], element[33:2], removed_count[40:34],
//                       zero pad to 48; tlast: last
//
//  One command is taken at a time; s_axis_tready is high only while idle.
//  Insert, clear and commands on an empty list finish in S_EXEC. Dump reads
//  each element from the store and then passes it through the output register.
//  Remove reads, compares and rewrites one store entry per cycle.
//  Unused commands return to idle with no result word.
//  Reset clears head, occupancy and control; the store itself is not cleared.
//  A stalled m_axis holds the engine in place; a new command may be taken
//  while the last result still waits in the output register.
//
module bounded_ordered_list_engine #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// cmd[2:0], operand_value[34:3], pad[39:35]
	input  logic [bole_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status[1:0], element[33:2], removed_count[40:34], pad[47:41]
	output logic [bole_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [IW-1:0]         idx_t;
	typedef logic [CW-1:0]         cnt_t;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_EXEC     = 3'd1;
	localparam logic [2:0] S_DUMP_RD  = 3'd2;
	localparam logic [2:0] S_DUMP_OUT = 3'd3;
	localparam logic [2:0] S_RM       = 3'd4;
	localparam logic [2:0] S_RM_DONE  = 3'd5;

	function automatic idx_t slot_of(input idx_t hd, input idx_t off);
		logic [IW:0] sum;
		sum = {1'b0, hd} + {1'b0, off};
		if (sum >= (IW+1)'(DEPTH))
			sum = sum - (IW+1)'(DEPTH);
		return sum[IW-1:0];
	endfunction

	logic [2:0]        state_q;
	bole_pkg::cmd_t    cmd_q;
	word_t             word_q;
	idx_t              head_q;
	cnt_t              occ_q;
	cnt_t              idx_q;
	cnt_t              kept_q;
	logic              rd_pend_q;

	// ring store
	word_t             mem_q [DEPTH];
	word_t             rd_data_q;
	logic              mem_we;
	idx_t              mem_waddr;
	word_t             mem_wdata;
	logic              mem_re;
	idx_t              mem_raddr;

	// output register
	logic              out_valid_q;
	bole_pkg::status_t out_status_q;
	bole_pkg::elem_t   out_elem_q;
	bole_pkg::rcnt_t   out_rcnt_q;
	logic              out_last_q;
	logic              out_free;

	logic              emit;
	bole_pkg::status_t emit_status;
	bole_pkg::elem_t   emit_elem;
	bole_pkg::rcnt_t   emit_rcnt;
	logic              emit_last;

	logic              in_fire;
	logic              full;
	logic              is_match;
	idx_t              head_dec;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign full     = (occ_q >= cnt_t'(DEPTH));
	assign is_match = (rd_data_q == word_q);
	assign head_dec = (head_q == '0) ? idx_t'(DEPTH - 1) : head_q - idx_t'(1);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'b0, out_rcnt_q, out_elem_q, out_status_q};

	// store ports and result selection
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = head_dec;
		mem_wdata   = word_q;
		mem_re      = 1'b0;
		mem_raddr   = slot_of(head_q, idx_q[IW-1:0]);
		emit        = 1'b0;
		emit_status = bole_pkg::ST_OK;
		emit_elem   = '0;
		emit_rcnt   = '0;
		emit_last   = 1'b1;
		unique case (state_q)
			S_EXEC: begin
				if (out_free) begin
					case (cmd_q)
						bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK: begin
							emit = 1'b1;
							if (full) begin
								emit_status = bole_pkg::ST_FULL;
							end else begin
								mem_we = 1'b1;
								if (cmd_q == bole_pkg::CMD_INS_BACK)
									mem_waddr = slot_of(head_q, occ_q[IW-1:0]);
							end
						end
						bole_pkg::CMD_DUMP, bole_pkg::CMD_REMOVE,
						bole_pkg::CMD_CLEAR: begin
							if (occ_q == '0) begin
								emit        = 1'b1;
								emit_status = bole_pkg::ST_EMPTY;
							end else if (cmd_q == bole_pkg::CMD_CLEAR) begin
								emit = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DUMP_RD: begin
				mem_re = 1'b1;
			end
			S_DUMP_OUT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_elem = bole_pkg::elem_t'(signed'(rd_data_q));
					emit_last = (idx_q + cnt_t'(1) == occ_q);
				end
			end
			S_RM: begin
				// compact: write survivors back at the kept position
				mem_we    = rd_pend_q && !is_match;
				mem_waddr = slot_of(head_q, kept_q[IW-1:0]);
				mem_wdata = rd_data_q;
				mem_re    = (idx_q < occ_q);
			end
			S_RM_DONE: begin
				if (out_free) begin
					emit = 1'b1;
					if (kept_q == occ_q)
						emit_status = bole_pkg::ST_NOTFOUND;
					else
						emit_rcnt = bole_pkg::rcnt_t'(occ_q - kept_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= bole_pkg::cmd_t'(s_axis_tdata[bole_pkg::CMD_W-1:0]);
			word_q <= word_t'(signed'(
				s_axis_tdata[bole_pkg::CMD_W +: bole_pkg::OPERAND_W]));
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_elem_q   <= emit_elem;
			out_rcnt_q   <= emit_rcnt;
			out_last_q   <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			idx_q       <= '0;
			kept_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						idx_q     <= '0;
						kept_q    <= '0;
						rd_pend_q <= 1'b0;
						state_q   <= S_IDLE;
						case (cmd_q)
							bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK: begin
								if (!full) begin
									occ_q <= occ_q + cnt_t'(1);
									if (cmd_q == bole_pkg::CMD_INS_FRONT)
										head_q <= head_dec;
								end
							end
							bole_pkg::CMD_DUMP: begin
								if (occ_q != '0)
									state_q <= S_DUMP_RD;
							end
							bole_pkg::CMD_REMOVE: begin
								if (occ_q != '0)
									state_q <= S_RM;
							end
							bole_pkg::CMD_CLEAR: begin
								occ_q  <= '0;
								head_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP_RD: begin
					state_q <= S_DUMP_OUT;
				end
				S_DUMP_OUT: begin
					if (out_free) begin
						idx_q   <= idx_q + cnt_t'(1);
						state_q <= emit_last ? S_IDLE : S_DUMP_RD;
					end
				end
				S_RM: begin
					if (rd_pend_q && !is_match)
						kept_q <= kept_q + cnt_t'(1);
					if (idx_q < occ_q) begin
						idx_q     <= idx_q + cnt_t'(1);
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
					end
					// last compare happens this cycle
					if (rd_pend_q && idx_q == occ_q)
						state_q <= S_RM_DONE;
				end
				S_RM_DONE: begin
					if (out_free) begin
						occ_q   <= kept_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cnt_t'(DEPTH))
		else $error("occupancy exceeds depth");

	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM) |-> (kept_q <= idx_q))
		else $error("compaction write passed the read index");

	a_dump_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP_OUT) |-> (idx_q < occ_q))
		else $error("dump index beyond occupancy");

	a_rm_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM_DONE && out_free) |=> (occ_q == $past(kept_q)))
		else $error("remove did not commit survivor count");

endmodule

FILE: sim/bole_checker.sv
// ----------------------------------------------------------------------------
// bole_checker - result checker for the bounded ordered list engine
// Watches both stream channels, keeps its own copy of the ring list, predicts
// every result word of each accepted command and compares them in order.
// ----------------------------------------------------------------------------
module bole_checker #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// cmd[2:0], operand_value[34:3], pad[39:35]
	input  logic [bole_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// status[1:0], element[33:2], removed_count[40:34], pad[47:41]
	input  logic [bole_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tlast,
	output int                               fail_count,
	output int                               pending,
	output int                               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		bole_pkg::status_t status;
		bole_pkg::elem_t   element;
		bole_pkg::rcnt_t   rcnt;
		logic              last;
	} list_result_t;

	word_t        ring_mem [DEPTH];
	int           head_pos;
	int           fill_count;
	list_result_t expected_results [$];

	function automatic word_t to_word(input bole_pkg::operand_t v);
		logic signed [63:0] wide;
		wide = $signed(v);
		return wide[DATA_WIDTH-1:0];
	endfunction

	function automatic bole_pkg::elem_t to_elem(input word_t w);
		logic signed [63:0] wide;
		wide = $signed(w);
		return wide[bole_pkg::ELEM_W-1:0];
	endfunction

	function automatic int ring_slot(input int offset);
		return (head_pos + offset) % DEPTH;
	endfunction

	task automatic push_result(input bole_pkg::status_t st, input bole_pkg::elem_t el,
			input bole_pkg::rcnt_t rc, input logic lst);
		list_result_t r;
		r.status  = st;
		r.element = el;
		r.rcnt    = rc;
		r.last    = lst;
		expected_results.push_back(r);
	endtask

	task automatic predict_cmd(input bole_pkg::cmd_t cmd, input bole_pkg::operand_t opnd);
		word_t w;
		word_t e;
		int    kept;
		int    gone;
		w = to_word(opnd);
		case (cmd)
			bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK: begin
				if (fill_count >= DEPTH) begin
					push_result(bole_pkg::ST_FULL, '0, '0, 1'b1);
				end else begin
					if (cmd == bole_pkg::CMD_INS_FRONT) begin
						head_pos = (head_pos + DEPTH - 1) % DEPTH;
						ring_mem[head_pos] = w;
					end else begin
						ring_mem[ring_slot(fill_count)] = w;
					end
					fill_count++;
					push_result(bole_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			bole_pkg::CMD_DUMP: begin
				if (fill_count == 0) begin
					push_result(bole_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int i = 0; i < fill_count; i++)
						push_result(bole_pkg::ST_OK, to_elem(ring_mem[ring_slot(i)]), '0,
							i == fill_count - 1);
				end
			end
			bole_pkg::CMD_REMOVE: begin
				if (fill_count == 0) begin
					push_result(bole_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					// compact survivors toward the head, order kept
					kept = 0;
					for (int i = 0; i < fill_count; i++) begin
						e = ring_mem[ring_slot(i)];
						if (e != w) begin
							ring_mem[ring_slot(kept)] = e;
							kept++;
						end
					end
					gone = fill_count - kept;
					fill_count = kept;
					if (gone == 0)
						push_result(bole_pkg::ST_NOTFOUND, '0, '0, 1'b1);
					else
						push_result(bole_pkg::ST_OK, '0, bole_pkg::rcnt_t'(gone), 1'b1);
				end
			end
			bole_pkg::CMD_CLEAR: begin
				if (fill_count == 0) begin
					push_result(bole_pkg::ST_EMPTY, '0, '0, 1'b1);
				end else begin
					fill_count = 0;
					head_pos   = 0;
					push_result(bole_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : monitor
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			head_pos   = 0;
			fill_count = 0;
			expected_results.delete();
		end else begin
			// the result word always belongs to an older command, so check it first
			if (m_tvalid && m_tready) begin
				got.status  = m_tdata[1:0];
				got.element = m_tdata[33:2];
				got.rcnt    = m_tdata[40:34];
				got.last    = m_tlast;
				checked++;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("%t unexpected result word: status %0d element %h %s",
							$realtime, got.status, got.element,
							$sformatf("count %0d last %b", got.rcnt, got.last));
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.status !== want.status || got.element !== want.element ||
							got.rcnt !== want.rcnt || got.last !== want.last) begin
						if (fail_count < 10) begin
							$display("%t mismatch: exp status %0d element %h count %0d last %b",
								$realtime, want.status, want.element, want.rcnt, want.last);
							$display("%t           got status %0d element %h count %0d last %b",
								$realtime, got.status, got.element, got.rcnt, got.last);
						end
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_cmd(s_tdata[2:0], s_tdata[34:3]);
		end
		pending = expected_results.size();
	end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench top for the bounded ordered list engine
// Drives directed and random list commands in bursts against a stalling
// result sink; the checker beside the engine predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 32;
	localparam int DATA_WIDTH  = 32;
	localparam int CYCLE_LIMIT = 400000;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [bole_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [bole_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;

	int fail_count;
	int pending;
	int checked;

	int                 cycles      = 0;
	int                 items_sent  = 0;
	int                 ignored_sent = 0;
	int                 burst_left  = 0;
	bit                 gaps_on     = 1'b1;
	int                 rx_mode     = 0;
	int                 rx_left     = 0;
	int                 rx_phase    = 0;
	bole_pkg::operand_t pool [3];

	always #5 clk = ~clk;

	bounded_ordered_list_engine #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	bole_checker #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tlast    (m_axis_tlast),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// result sink: switch between always ready, 3 of 4, coin flip and long stalls
	always @(negedge clk) begin
		rx_phase <= rx_phase + 1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= (rx_phase % 4) != 3;
			2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= (rx_phase % 11) >= 5;
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_cmd(input bole_pkg::cmd_t cmd, input bole_pkg::operand_t val);
		if (gaps_on && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(bole_pkg::IN_TDATA_W - bole_pkg::OPERAND_W - bole_pkg::CMD_W){1'b0}},
			val, cmd};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (cmd <= bole_pkg::CMD_CLEAR)
			items_sent++;
		else
			ignored_sent++;
	endtask

	// hold off until every predicted word has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic bole_pkg::operand_t pick_operand();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return pool[$urandom_range(0, 2)];
		if (r == 6) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic bole_pkg::cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 28) return bole_pkg::CMD_INS_FRONT;
		if (r < 56) return bole_pkg::CMD_INS_BACK;
		if (r < 68) return bole_pkg::CMD_DUMP;
		if (r < 88) return bole_pkg::CMD_REMOVE;
		if (r < 94) return bole_pkg::CMD_CLEAR;
		return bole_pkg::cmd_t'($urandom_range(5, 7));
	endfunction

	task automatic run_mixed(input int n);
		for (int i = 0; i < n; i++)
			send_cmd(pick_cmd(), pick_operand());
	endtask

	// fill past full with few distinct values, then dump, strip and dump again
	task automatic run_fill();
		int npool;
		npool = $urandom_range(1, 3);
		for (int i = 0; i < DEPTH + 2; i++)
			send_cmd($urandom_range(0, 1) ? bole_pkg::CMD_INS_FRONT : bole_pkg::CMD_INS_BACK,
				pool[$urandom_range(0, npool - 1)]);
		send_cmd(bole_pkg::CMD_DUMP, $urandom);
		send_cmd(bole_pkg::CMD_REMOVE, pool[0]);
		send_cmd(bole_pkg::CMD_DUMP, $urandom);
		if ($urandom_range(0, 1))
			send_cmd(bole_pkg::CMD_CLEAR, $urandom);
		else
			send_cmd(bole_pkg::CMD_REMOVE, pool[npool - 1]);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list and unused codes
		send_cmd(bole_pkg::CMD_DUMP, 32'h0);
		send_cmd(bole_pkg::CMD_REMOVE, 32'h5);
		send_cmd(bole_pkg::CMD_CLEAR, 32'hffff_ffff);
		send_cmd(bole_pkg::cmd_t'(5), $urandom);
		send_cmd(bole_pkg::cmd_t'(6), $urandom);
		send_cmd(bole_pkg::cmd_t'(7), $urandom);
		// field extremes, duplicates, not found and match removal
		send_cmd(bole_pkg::CMD_INS_FRONT, 32'h7fff_ffff);
		send_cmd(bole_pkg::CMD_INS_FRONT, 32'h8000_0000);
		send_cmd(bole_pkg::CMD_INS_BACK, 32'h0000_0000);
		send_cmd(bole_pkg::CMD_INS_BACK, 32'hffff_ffff);
		send_cmd(bole_pkg::CMD_INS_BACK, 32'h8000_0000);
		send_cmd(bole_pkg::CMD_DUMP, 32'h0);
		send_cmd(bole_pkg::CMD_REMOVE, 32'h1234_5678);
		send_cmd(bole_pkg::CMD_REMOVE, 32'h8000_0000);
		send_cmd(bole_pkg::CMD_DUMP, 32'h0);
		send_cmd(bole_pkg::CMD_CLEAR, 32'h0);
		send_cmd(bole_pkg::CMD_DUMP, 32'h0);
		// empty the list by removal alone
		send_cmd(bole_pkg::CMD_INS_BACK, 32'ha5a5_a5a5);
		send_cmd(bole_pkg::CMD_INS_FRONT, 32'h5a5a_5a5a);
		send_cmd(bole_pkg::CMD_REMOVE, 32'ha5a5_a5a5);
		send_cmd(bole_pkg::CMD_REMOVE, 32'h5a5a_5a5a);
		send_cmd(bole_pkg::CMD_DUMP, 32'h0);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			for (int k = 0; k < 3; k++)
				pool[k] = $urandom;
			gaps_on = $urandom_range(0, 3) != 0;
			if (p % 2 == 0)
				run_mixed(16);
			else
				run_fill();
			wait_drained();
		end

		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		$display("Sent %0d list commands and %0d unused codes; %0d result words checked.",
			items_sent, ignored_sent, checked);
		$display("Covered empty, full, not-found, multi-match removal and full-depth dumps.");
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
